// ===== design/sjc_pkg.sv =====
// Shared types and constants for the Shift_JIS to EUC-JP converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package sjc_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] KANA_LOW_EXCL  = 8'hA0;
   localparam logic [7:0] KANA_HIGH_EXCL = 8'hE0;
   localparam logic [7:0] KANA_PREFIX    = 8'h8E;
   localparam logic [7:0] ASCII_MAX      = 8'h7F;
   localparam logic [7:0] LEAD_SPLIT     = 8'h9F;
   localparam logic [7:0] LEAD_OFS_LOW   = 8'h71;
   localparam logic [7:0] LEAD_OFS_HIGH  = 8'hB1;
   localparam logic [7:0] TRAIL_SPLIT    = 8'h9E;
   localparam logic [7:0] TRAIL_OFS_HIGH = 8'h7D;
   localparam logic [7:0] TRAIL_OFS_LOW  = 8'h1F;
   localparam logic [7:0] HIGH_BIT       = 8'h80;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
      logic       truncated;
   } rsp_type;

   // One queued command: one or two output bytes for a single input beat.
   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic       two_bytes;
      logic       last;
      logic       trunc;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== design/sjc_front.sv =====
// Front end: accepts input beats, tracks the pending lead byte and
// builds output commands. Depends on sjc_pkg.
`default_nettype none

module sjc_front
   import sjc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output logic         push,
   output cmd_type      cmd
);

   logic       lead_pending_ff, lead_pending_in;
   logic [7:0] lead_value_ff, lead_value_in;
   logic [7:0] h_sub, h_dbl, l_dec, trail_out, lead_out;
   logic       is_kana, is_high;

   // Double-byte rearrangement of the held lead and the arriving trail.
   always_comb begin
      h_sub = lead_value_ff - ((lead_value_ff <= LEAD_SPLIT) ? LEAD_OFS_LOW : LEAD_OFS_HIGH);
      h_dbl = {h_sub[6:0], 1'b1};
      l_dec = (req.in_byte > ASCII_MAX) ? req.in_byte - 8'd1 : req.in_byte;
      if (l_dec >= TRAIL_SPLIT) begin
         trail_out = l_dec - TRAIL_OFS_HIGH;
         lead_out  = h_dbl + 8'd1;
      end else begin
         trail_out = l_dec - TRAIL_OFS_LOW;
         lead_out  = h_dbl;
      end
   end

   assign is_kana = (req.in_byte > KANA_LOW_EXCL) && (req.in_byte < KANA_HIGH_EXCL);
   assign is_high = req.in_byte > ASCII_MAX;

   always_comb begin
      lead_pending_in = lead_pending_ff;
      lead_value_in   = lead_value_ff;
      push            = 1'b0;
      cmd.first_byte  = req.in_byte;
      cmd.second_byte = req.in_byte;
      cmd.two_bytes   = 1'b0;
      cmd.last        = req.in_last;
      cmd.trunc       = 1'b0;
      if (accept) begin
         if (lead_pending_ff) begin
            push            = 1'b1;
            cmd.first_byte  = lead_out | HIGH_BIT;
            cmd.second_byte = trail_out | HIGH_BIT;
            cmd.two_bytes   = 1'b1;
            lead_pending_in = 1'b0;
            lead_value_in   = 8'd0;
         end else if (is_kana) begin
            push           = 1'b1;
            cmd.first_byte = KANA_PREFIX;
            cmd.two_bytes  = 1'b1;
         end else if (is_high) begin
            if (req.in_last) begin
               // A lead byte at the end of the string has no trail to pair with.
               push           = 1'b1;
               cmd.first_byte = 8'd0;
               cmd.trunc      = 1'b1;
            end else begin
               lead_pending_in = 1'b1;
               lead_value_in   = req.in_byte;
            end
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_value_ff   <= 8'd0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_value_ff   <= lead_value_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sjc_queue.sv =====
// Short command queue between the front and back ends.
// Depends on sjc_pkg.
`default_nettype none

module sjc_queue
   import sjc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   cmd_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_MAX) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_MAX) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_MAX);
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== design/sjc_back.sv =====
// Back end: takes commands from the queue and sends one output beat per cycle
// while rsp_stall is low, from a held command register. Depends on sjc_pkg.
`default_nettype none

module sjc_back
   import sjc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type head_cmd,
   input  wire logic    queue_empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   cmd_type cur_ff;
   logic    cur_valid_ff, cur_valid_in;
   logic    phase_ff, phase_in;
   logic    final_beat, beat_done;

   assign final_beat = !cur_ff.two_bytes || phase_ff;
   assign beat_done  = cur_valid_ff && !rsp_stall;

   // A new command loads when nothing is held or the held one sends its final beat.
   assign pop = !queue_empty && (!cur_valid_ff || (beat_done && final_beat));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         phase_in     = 1'b0;
      end else if (beat_done) begin
         if (final_beat) begin
            cur_valid_in = 1'b0;
            phase_in     = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_cmd;
      end
   end

   assign rsp_valid              = cur_valid_ff;
   assign rsp_payload.out_byte   = phase_ff ? cur_ff.second_byte : cur_ff.first_byte;
   assign rsp_payload.run_last   = final_beat;
   assign rsp_payload.string_end = final_beat && cur_ff.last;
   assign rsp_payload.truncated  = cur_ff.trunc;

endmodule

`default_nettype wire

// ===== design/sjis_to_eucjp_converter.sv =====
// Shift_JIS to EUC-JP converter: request channel of Shift_JIS bytes in,
// response channel of EUC-JP bytes out. Uses sjc_pkg and the sjc_* modules.
//
// Usage:
//   req_* carries one Shift_JIS byte per beat with in_last on the final
//   byte of a string. rsp_* returns EUC-JP bytes, each flagged with
//   run_last (last byte caused by that input), string_end and truncated.
//   A beat moves when valid is high and stall is low.
// Timing: the command queue is written at the edge that accepts the
//   request beat, and the output command register then loads from the
//   queue head once it is free; response beats come from that register.
// Throughput: a request beat is taken every cycle while the command queue
//   has room. The response side sends one beat per cycle while rsp_stall is
//   low. Half-width kana give two response beats per input byte, a
//   double-byte pair two and ASCII one; a lead byte without last produces
//   nothing until its trail. The output register limits sustained rate.
// Stall: rsp_stall holds the current response beat; the queue (QUEUE_DEPTH
//   commands) keeps absorbing requests until full, then req_stall rises.
// Reset: synchronous and active high; clears the pending lead byte, the
//   queue counters and the output valid flags. No clearing pass is needed.
`default_nettype none

module sjis_to_eucjp_converter
   import sjc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic             req_accept;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type queue_status;

   assign req_stall  = queue_status.full;
   assign req_accept = req_valid && !req_stall;

   sjc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_payload),
      .push   (push),
      .cmd    (push_cmd)
   );

   sjc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   sjc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .queue_empty (queue_status.empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // The queue can never report full and empty together.
   assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty together");

   // Nothing is offered on the response side in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A truncation beat is a lone zero byte that ends its string.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.truncated) |->
         (rsp_payload.out_byte == 8'd0 && rsp_payload.run_last && rsp_payload.string_end))
      else $error("malformed truncation beat");

   // A string can only end on the last beat of its input byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.string_end) |-> rsp_payload.run_last)
      else $error("string end without run last");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sjis_to_eucjp_converter_tb.sv =====
// Self-checking testbench for sjis_to_eucjp_converter: Shift_JIS strings in,
// EUC-JP bytes compared against a behavioral predictor. Depends on sjc_pkg.
`timescale 1ns / 1ps

module sjis_to_eucjp_converter_tb;
   import sjc_pkg::*;

   localparam int PRESSURE_HOLD   = 60;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int RANDOM_ITEMS    = 400;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // Predictor state: a Shift_JIS lead byte waiting for its trail.
   logic       lead_waiting;
   logic [7:0] lead_byte;
   rsp_type    expected_eucjp[$];

   int  failures;
   int  items_sent;
   bit  sender_quiet;
   bit  pressure_request;

   sjis_to_eucjp_converter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic void push_eucjp(input logic [7:0] b, input logic rl, input logic se,
                                      input logic tr);
      rsp_type r;
      r.out_byte   = b;
      r.run_last   = rl;
      r.string_end = se;
      r.truncated  = tr;
      expected_eucjp.push_back(r);
   endfunction

   function automatic void convert_beat(input logic [7:0] b, input logic l);
      logic [7:0] hi;
      logic [7:0] lo;
      if (lead_waiting) begin
         hi = lead_byte - ((lead_byte <= LEAD_SPLIT) ? LEAD_OFS_LOW : LEAD_OFS_HIGH);
         hi = {hi[6:0], 1'b1};
         lo = b;
         if (lo > ASCII_MAX) lo = lo - 8'd1;
         if (lo >= TRAIL_SPLIT) begin
            lo = lo - TRAIL_OFS_HIGH;
            hi = hi + 8'd1;
         end else begin
            lo = lo - TRAIL_OFS_LOW;
         end
         lead_waiting = 1'b0;
         lead_byte    = 8'h00;
         push_eucjp(hi | HIGH_BIT, 1'b0, 1'b0, 1'b0);
         push_eucjp(lo | HIGH_BIT, 1'b1, l, 1'b0);
      end else if (b > KANA_LOW_EXCL && b < KANA_HIGH_EXCL) begin
         push_eucjp(KANA_PREFIX, 1'b0, 1'b0, 1'b0);
         push_eucjp(b, 1'b1, l, 1'b0);
      end else if (b > ASCII_MAX) begin
         // A lead byte closing the string can never get its trail.
         if (l) begin
            lead_waiting = 1'b0;
            lead_byte    = 8'h00;
            push_eucjp(8'h00, 1'b1, 1'b1, 1'b1);
         end else begin
            lead_waiting = 1'b1;
            lead_byte    = b;
         end
      end else begin
         push_eucjp(b, 1'b1, l, 1'b0);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_quiet) return 0;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(5, 20);
   endfunction

   function automatic logic [7:0] pick_ascii();
      return 8'($urandom_range(1, 127));
   endfunction

   function automatic logic [7:0] pick_kana();
      return 8'($urandom_range(8'hA1, 8'hDF));
   endfunction

   function automatic logic [7:0] pick_lead();
      if ($urandom_range(0, 1)) return 8'($urandom_range(8'h80, 8'hA0));
      return 8'($urandom_range(8'hE0, 8'hFF));
   endfunction

   function automatic logic [7:0] pick_trail();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
      return 8'($urandom_range(8'h40, 8'hFC));
   endfunction

   // Entered and left at a falling edge; the beat is predicted at the edge
   // where it is taken.
   task automatic send_byte(input logic [7:0] b, input logic l);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           = 1'b1;
      req_payload.in_byte = b;
      req_payload.in_last = l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      convert_beat(b, l);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_string(input int n_chars, input bit dangle);
      int  k;
      int  kind;
      bit  closing;
      for (k = 0; k < n_chars; k++) begin
         kind    = $urandom_range(0, 9);
         closing = (k == n_chars - 1) && !dangle;
         if (kind < 4) begin
            send_byte(pick_ascii(), closing);
         end else if (kind < 6) begin
            send_byte(pick_kana(), closing);
         end else begin
            send_byte(pick_lead(), 1'b0);
            send_byte(pick_trail(), closing);
         end
      end
      if (dangle) send_byte(pick_lead(), 1'b1);
   endtask

   task automatic test_directed();
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hA1, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h9E, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h9D, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(8'hFC, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      // Half-width kana value taken as a trail byte.
      send_byte(8'hE0, 1'b0);
      send_byte(8'hA1, 1'b0);
      send_byte(8'h88, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h82, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hDF, 1'b1);
      send_byte(8'h7F, 1'b1);
   endtask

   // The receiver holds off while beats keep coming, so the queue fills
   // and the input side has to stall.
   task automatic test_backpressure();
      int k;
      sender_quiet     = 1'b1;
      pressure_request = 1'b1;
      for (k = 0; k < 10; k++) send_string(3, 1'b0);
      sender_quiet = 1'b0;
   endtask

   task automatic test_random_strings();
      int start;
      int r;
      int k;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         sender_quiet = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 19);
         if (r < 16) begin
            send_string($urandom_range(1, 10), 1'b0);
         end else if (r < 18) begin
            send_string($urandom_range(0, 6), 1'b1);
         end else begin
            for (k = $urandom_range(1, 8); k > 0; k--)
               send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
         end
      end
      sender_quiet = 1'b0;
   endtask

   task automatic wait_drained();
      int n;
      n = 0;
      while (expected_eucjp.size() > 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (expected_eucjp.size() > 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, expected_eucjp.size());
         failures++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Output checker: every beat taken on the response side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_eucjp.size() == 0) begin
            $display("%0t: unexpected beat, got byte %02h run_last %b string_end %b truncated %b",
                     $time, rsp_payload.out_byte, rsp_payload.run_last,
                     rsp_payload.string_end, rsp_payload.truncated);
            failures++;
         end else begin
            if (rsp_payload.out_byte !== expected_eucjp[0].out_byte ||
                rsp_payload.run_last !== expected_eucjp[0].run_last ||
                rsp_payload.string_end !== expected_eucjp[0].string_end ||
                rsp_payload.truncated !== expected_eucjp[0].truncated) begin
               $display("%0t: mismatch, expected byte %02h run_last %b string_end %b truncated %b",
                        $time, expected_eucjp[0].out_byte, expected_eucjp[0].run_last,
                        expected_eucjp[0].string_end, expected_eucjp[0].truncated);
               $display("%0t:           got byte %02h run_last %b string_end %b truncated %b",
                        $time, rsp_payload.out_byte, rsp_payload.run_last,
                        rsp_payload.string_end, rsp_payload.truncated);
               failures++;
            end
            void'(expected_eucjp.pop_front());
         end
      end
   end

   // Response-side stall pattern: runs of free cycles, short holds and the
   // occasional long one, plus the long hold that the pressure test asks for.
   initial begin : rsp_stall_gen
      int hold_left;
      int free_left;
      int r;
      hold_left = 0;
      free_left = 0;
      forever begin
         @(negedge clock);
         if (pressure_request) begin
            pressure_request = 1'b0;
            hold_left        = PRESSURE_HOLD;
            free_left        = 0;
         end
         if (hold_left == 0 && free_left == 0) begin
            r = $urandom_range(0, 9);
            if (r < 4) free_left = $urandom_range(1, 40);
            else if (r < 9) hold_left = $urandom_range(1, 3);
            else hold_left = $urandom_range(6, 20);
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = 1'b0;
            free_left--;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      rsp_stall        = 1'b0;
      lead_waiting     = 1'b0;
      lead_byte        = 8'h00;
      failures         = 0;
      items_sent       = 0;
      sender_quiet     = 1'b0;
      pressure_request = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random_strings();
      wait_drained();

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
